[rtl/core/ms_pkg.sv]
package ms_pkg;

    // Element width and store geometry
    localparam int DATA_W    = 32;
    localparam int DEPTH     = 64;
    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // Top-level sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_MERGE,
        ST_PRE,
        ST_EMIT
    } t_state;

    // Merge controller to datapath
    typedef struct packed {
        logic [ADDR_W-1:0] rd_a;
        logic [ADDR_W-1:0] rd_b;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_en;
        logic              take_a;
        logic              src_scr;
        logic              done;
    } t_merge_ctl;

endpackage

[rtl/core/ms_merge_ctl.sv]
module ms_merge_ctl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ms_pkg::CNT_W-1:0]      i_count,
    input  logic [ms_pkg::DATA_W-1:0]     i_q_a,
    input  logic [ms_pkg::DATA_W-1:0]     i_q_b,
    output ms_pkg::t_merge_ctl            o_ctl
);

    localparam int SUM_W = ms_pkg::CNT_W + 2;

    logic                     r_busy, n_busy;
    logic                     r_wait, n_wait;
    logic                     r_src_scr, n_src_scr;
    logic [ms_pkg::CNT_W-1:0] r_width, n_width;
    logic [ms_pkg::CNT_W-1:0] r_mid, n_mid;
    logic [ms_pkg::CNT_W-1:0] r_hi, n_hi;
    logic [ms_pkg::CNT_W-1:0] r_i, n_i;
    logic [ms_pkg::CNT_W-1:0] r_j, n_j;
    logic [ms_pkg::CNT_W-1:0] r_k, n_k;

    logic             active;
    logic             take_a;
    logic             run_end;
    logic             pass_end;
    logic             sort_done;
    logic [SUM_W-1:0] cnt_x;
    logic [SUM_W-1:0] hi_x;
    logic [SUM_W-1:0] wid_x;
    logic [SUM_W-1:0] wid2_x;

    // Bound a run edge by the set size
    function automatic logic [ms_pkg::CNT_W-1:0] f_clip(
        input logic [SUM_W-1:0]         v,
        input logic [ms_pkg::CNT_W-1:0] lim
    );
        logic [SUM_W-1:0] lim_x;
        lim_x = SUM_W'(lim);
        return (v > lim_x) ? lim : v[ms_pkg::CNT_W-1:0];
    endfunction

    assign cnt_x  = SUM_W'(i_count);
    assign hi_x   = SUM_W'(r_hi);
    assign wid_x  = SUM_W'(r_width);
    assign wid2_x = wid_x << 1;

    // Pick the lower head; the left run wins ties to keep arrival order
    assign active   = r_busy && !r_wait;
    assign take_a   = (r_i < r_mid) &&
                      ((r_j >= r_hi) || ($signed(i_q_a) <= $signed(i_q_b)));
    assign run_end  = active && ((r_k + ms_pkg::CNT_W'(1)) == r_hi);
    assign pass_end = run_end && (r_hi == i_count);
    assign sort_done = pass_end && (wid2_x >= cnt_x);

    // Advance run indexes, runs and passes
    always_comb begin
        n_busy    = r_busy;
        n_wait    = 1'b0;
        n_src_scr = r_src_scr;
        n_width   = r_width;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        if (i_start) begin
            n_busy    = (i_count > ms_pkg::CNT_W'(1));
            n_src_scr = 1'b0;
            n_width   = ms_pkg::CNT_W'(1);
            n_i       = '0;
            n_mid     = ms_pkg::CNT_W'(1);
            n_j       = ms_pkg::CNT_W'(1);
            n_hi      = f_clip(SUM_W'(2), i_count);
            n_k       = '0;
        end else if (active) begin
            if (!run_end) begin
                n_k = r_k + ms_pkg::CNT_W'(1);
                if (take_a) begin
                    n_i = r_i + ms_pkg::CNT_W'(1);
                end else begin
                    n_j = r_j + ms_pkg::CNT_W'(1);
                end
            end else if (!pass_end) begin
                n_i   = r_hi;
                n_k   = r_hi;
                n_mid = f_clip(hi_x + wid_x, i_count);
                n_j   = f_clip(hi_x + wid_x, i_count);
                n_hi  = f_clip(hi_x + wid2_x, i_count);
            end else begin
                n_src_scr = !r_src_scr;
                n_width   = wid2_x[ms_pkg::CNT_W-1:0];
                if (sort_done) begin
                    n_busy = 1'b0;
                end else begin
                    // Re-read the new source after its last write lands
                    n_wait = 1'b1;
                    n_i    = '0;
                    n_k    = '0;
                    n_mid  = wid2_x[ms_pkg::CNT_W-1:0];
                    n_j    = wid2_x[ms_pkg::CNT_W-1:0];
                    n_hi   = f_clip(wid2_x << 1, i_count);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_wait    <= 1'b0;
            r_src_scr <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_wait    <= n_wait;
            r_src_scr <= n_src_scr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_width <= n_width;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
    end

    // Read next heads so the registered data matches the held indexes
    always_comb begin
        o_ctl.rd_a    = n_i[ms_pkg::ADDR_W-1:0];
        o_ctl.rd_b    = n_j[ms_pkg::ADDR_W-1:0];
        o_ctl.wr_addr = r_k[ms_pkg::ADDR_W-1:0];
        o_ctl.wr_en   = active;
        o_ctl.take_a  = take_a;
        o_ctl.src_scr = r_src_scr;
        o_ctl.done    = sort_done;
    end

endmodule

[rtl/core/merge_sorter_unit.sv]
// Load: one cycle per item, s_axis_tready high while collecting a set.
// Sort of n items: a setup state (ST_START), ceil(log2 n) merge passes with a wait
// state between passes, then a state (ST_PRE) to prime the read port.
// Emit: one item per cycle while m_axis_tready allows, from the store's registered read port.
// The merge unit moves one item per cycle outside the wait between passes; the store's registered read sets that wait.
// Reset (i_rst_n low, synchronous) clears control and counts; stores are not cleared.
module merge_sorter_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic signed [ms_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] value
    input  logic                         s_axis_tlast,      // is_final
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic signed [ms_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] sorted_value
    output logic                         m_axis_tlast,      // final_out
    output logic [0:0]                   m_axis_tuser       // [0] overflow
);

    ms_pkg::t_state     r_state, n_state;
    ms_pkg::t_merge_ctl ctl;

    logic [ms_pkg::CNT_W-1:0]  r_count;
    logic                      r_drop;
    logic [ms_pkg::CNT_W-1:0]  r_e, n_e;
    logic                      r_ov;
    logic [ms_pkg::DATA_W-1:0] r_out_data;
    logic                      r_out_last;
    logic                      r_out_user;

    logic [ms_pkg::DATA_W-1:0] r_elm_mem [ms_pkg::DEPTH];
    logic [ms_pkg::DATA_W-1:0] r_scr_mem [ms_pkg::DEPTH];
    logic [ms_pkg::DATA_W-1:0] r_elm_qa, r_elm_qb, r_scr_qa, r_scr_qb;

    logic                      in_acc;
    logic                      has_room;
    logic                      load_we;
    logic                      ctl_start;
    logic                      emit_load;
    logic                      emit_last;
    logic [ms_pkg::ADDR_W-1:0] rd_addr_a;
    logic [ms_pkg::DATA_W-1:0] q_a, q_b;
    logic [ms_pkg::DATA_W-1:0] merge_wdata;
    logic                      elm_we;
    logic [ms_pkg::ADDR_W-1:0] elm_waddr;
    logic [ms_pkg::DATA_W-1:0] elm_wdata;
    logic                      scr_we;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign has_room  = r_count < ms_pkg::CNT_W'(ms_pkg::MAX_ITEMS);
    assign load_we   = in_acc && has_room;
    assign emit_last = (r_e + ms_pkg::CNT_W'(1)) == r_count;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ms_pkg::ST_LOAD: begin
                if (in_acc && s_axis_tlast) begin
                    n_state = ms_pkg::ST_START;
                end
            end
            ms_pkg::ST_START: begin
                n_state = (r_count > ms_pkg::CNT_W'(1)) ? ms_pkg::ST_MERGE : ms_pkg::ST_PRE;
            end
            ms_pkg::ST_MERGE: begin
                if (ctl.done) begin
                    n_state = ms_pkg::ST_PRE;
                end
            end
            ms_pkg::ST_PRE: begin
                n_state = ms_pkg::ST_EMIT;
            end
            ms_pkg::ST_EMIT: begin
                if (emit_load && emit_last) begin
                    n_state = ms_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = ms_pkg::ST_LOAD;
            end
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        ctl_start     = 1'b0;
        emit_load     = 1'b0;
        unique case (r_state)
            ms_pkg::ST_LOAD:  s_axis_tready = 1'b1;
            ms_pkg::ST_START: ctl_start     = 1'b1;
            ms_pkg::ST_MERGE: ;
            ms_pkg::ST_PRE:   ;
            ms_pkg::ST_EMIT:  emit_load     = (r_e < r_count) && (!r_ov || m_axis_tready);
            default:          ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ms_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    ms_merge_ctl u_merge_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctl_start),
        .i_count (r_count),
        .i_q_a   (q_a),
        .i_q_b   (q_b),
        .o_ctl   (ctl)
    );

    // Emit index; the read port runs one step ahead of it
    always_comb begin
        if (r_state == ms_pkg::ST_LOAD) begin
            n_e = '0;
        end else if (emit_load) begin
            n_e = r_e + ms_pkg::CNT_W'(1);
        end else begin
            n_e = r_e;
        end
    end

    assign rd_addr_a   = (r_state == ms_pkg::ST_MERGE) ? ctl.rd_a : n_e[ms_pkg::ADDR_W-1:0];
    assign q_a         = ctl.src_scr ? r_scr_qa : r_elm_qa;
    assign q_b         = ctl.src_scr ? r_scr_qb : r_elm_qb;
    assign merge_wdata = ctl.take_a ? q_a : q_b;

    // Write port muxing: load fills the element store, merges go to the other side
    assign elm_we    = load_we || (ctl.wr_en && ctl.src_scr);
    assign elm_waddr = (r_state == ms_pkg::ST_LOAD) ? r_count[ms_pkg::ADDR_W-1:0] : ctl.wr_addr;
    assign elm_wdata = (r_state == ms_pkg::ST_LOAD) ? s_axis_tdata : merge_wdata;
    assign scr_we    = ctl.wr_en && !ctl.src_scr;

    always_ff @(posedge i_clk) begin
        if (elm_we) begin
            r_elm_mem[elm_waddr] <= elm_wdata;
        end
        r_elm_qa <= r_elm_mem[rd_addr_a];
        r_elm_qb <= r_elm_mem[ctl.rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) begin
            r_scr_mem[ctl.wr_addr] <= merge_wdata;
        end
        r_scr_qa <= r_scr_mem[rd_addr_a];
        r_scr_qb <= r_scr_mem[ctl.rd_b];
    end

    // Count stored items, flag drops, reset both once the last item is emitted; track r_e, r_ov
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_e     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_e <= n_e;
            if (emit_load && emit_last) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end else if (in_acc) begin
                if (has_room) begin
                    r_count <= r_count + ms_pkg::CNT_W'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (emit_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_data <= q_a;
            r_out_last <= emit_last;
            r_out_user <= r_drop;
        end
    end

    assign m_axis_tvalid   = r_ov;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tlast    = r_out_last;
    assign m_axis_tuser[0] = r_out_user;

endmodule

[rtl/core/ms_checker.sv]
module ms_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic signed [ms_pkg::DATA_W-1:0]  s_axis_tdata,
    input logic                              s_axis_tlast,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic signed [ms_pkg::DATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tlast,
    input logic [0:0]                        m_axis_tuser
);

    logic                             in_acc;
    logic                             out_acc;
    logic                             r_in_set;
    logic signed [ms_pkg::DATA_W-1:0] r_prev;
    logic                             r_prev_user;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Track the previous item of the set being emitted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_set <= 1'b0;
        end else if (out_acc) begin
            r_in_set <= !m_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev      <= m_axis_tdata;
            r_prev_user <= m_axis_tuser[0];
        end
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Results of one set come out in ascending order
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_in_set |-> m_axis_tdata >= r_prev)
        else $error("results out of order");

    // Overflow flag is the same on every result of a set
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_in_set |-> m_axis_tuser[0] == r_prev_user)
        else $error("overflow flag changed within a set");

    // No new item is taken while a set is still being emitted
    a_no_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready during emit");

    // The final item of a set starts the sort
    a_final_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready right after final item");

endmodule

bind merge_sorter_unit ms_checker u_ms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

[dv/tb_merge_sorter_unit.sv]
module tb_merge_sorter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT        = 200000;
    localparam int DRAIN_CYCLES       = 50;
    localparam int RANDOM_SMALL_ITEMS = 120;
    localparam int DIR_ROWS           = 20;

    // One sorted item as it leaves the block
    typedef struct packed {
        logic signed [ms_pkg::DATA_W-1:0] value;
        logic                             final_flag;
        logic                             ovf;
    } t_sorted_item;

    // One row of the directed table; typed rows carry their result by hand
    typedef struct packed {
        logic signed [ms_pkg::DATA_W-1:0] value;
        logic                             last;
        logic                             typed;
        logic signed [ms_pkg::DATA_W-1:0] want;
    } t_stim_row;

    logic                             i_clk;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic signed [ms_pkg::DATA_W-1:0] s_axis_tdata  = '0;    // [31:0] value
    logic                             s_axis_tlast  = 1'b0;  // is_final
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic signed [ms_pkg::DATA_W-1:0] m_axis_tdata;          // [31:0] sorted_value
    logic                             m_axis_tlast;          // final_out
    logic [0:0]                       m_axis_tuser;          // [0] overflow

    // Sorter model state
    logic signed [ms_pkg::DATA_W-1:0] set_store [ms_pkg::DEPTH];
    int                               set_count   = 0;
    logic                             set_dropped = 1'b0;
    t_sorted_item                     sorted_expect [$];

    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        idle_phase     = 0;
    int        send_idle_pct  = 38;
    int        recv_stall_pct = 68;
    t_stim_row dir_rows [DIR_ROWS];

    merge_sorter_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Store or drop one element; on the final one sort the set and, if keep, queue its items
    task automatic absorb_element(input logic signed [ms_pkg::DATA_W-1:0] v,
                                  input logic last, input logic keep);
        logic signed [ms_pkg::DATA_W-1:0] key;
        int                               j;
        if (set_count < ms_pkg::MAX_ITEMS) begin
            set_store[set_count] = v;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            // stable insertion sort: equal values keep arrival order
            for (int i = 1; i < set_count; i++) begin
                key = set_store[i];
                j   = i - 1;
                while (j >= 0 && set_store[j] > key) begin
                    set_store[j + 1] = set_store[j];
                    j--;
                end
                set_store[j + 1] = key;
            end
            if (keep) begin
                for (int i = 0; i < set_count; i++)
                    sorted_expect.push_back(t_sorted_item'{set_store[i],
                                                           i == set_count - 1, set_dropped});
            end
            set_count   = 0;
            set_dropped = 1'b0;
        end
    endtask

    // Offer one element, hold it until accepted, then update the model
    task automatic send_element(input logic signed [ms_pkg::DATA_W-1:0] v, input logic last,
                                input logic typed,
                                input logic signed [ms_pkg::DATA_W-1:0] want);
        while (($urandom % 100) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        absorb_element(v, last, !typed);
        if (typed)
            sorted_expect.push_back(t_sorted_item'{want, 1'b1, 1'b0});
    endtask

    // Random set: a quarter of the values from a narrow band to force ties
    task automatic send_random_set(input int size);
        logic signed [ms_pkg::DATA_W-1:0] v;
        for (int k = 0; k < size; k++) begin
            if ($urandom_range(3) == 0)
                v = $urandom_range(8) - 4;
            else
                v = $urandom;
            send_element(v, k == size - 1, 1'b0, '0);
        end
    endtask

    // Check each accepted item against the oldest expectation; drive ready
    always @(posedge i_clk) begin : sorted_monitor
        t_sorted_item got;
        t_sorted_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_sorted_item'{m_axis_tdata, m_axis_tlast, m_axis_tuser[0]};
            if (sorted_expect.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected item: expected none, actual %0d last %0b ovf %0b",
                         $time, got.value, got.final_flag, got.ovf);
            end else begin
                want = sorted_expect.pop_front();
                if (got.value !== want.value || got.final_flag !== want.final_flag ||
                    got.ovf !== want.ovf) begin
                    mismatch_count++;
                    $display("%0t: mismatch: expected %0d last %0b ovf %0b, %s",
                             $time, want.value, want.final_flag, want.ovf,
                             $sformatf("actual %0d last %0b ovf %0b",
                                       got.value, got.final_flag, got.ovf));
                end
            end
        end
        m_axis_tready <= ($urandom % 100) >= recv_stall_pct;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int rand_items;
        int size;

        dir_rows = '{
            // single-element sets: the element comes straight back
            '{32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff},
            '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000},
            '{32'sh00000000, 1'b1, 1'b1, 32'sh00000000},
            '{32'shffffffff, 1'b1, 1'b1, 32'shffffffff},
            // duplicates and both extremes in one set
            '{32'sh00000005, 1'b0, 1'b0, '0},
            '{32'shfffffffd, 1'b0, 1'b0, '0},
            '{32'sh00000005, 1'b0, 1'b0, '0},
            '{32'sh7fffffff, 1'b0, 1'b0, '0},
            '{32'sh80000000, 1'b0, 1'b0, '0},
            '{32'shfffffffd, 1'b0, 1'b0, '0},
            '{32'sh00000000, 1'b0, 1'b0, '0},
            '{32'sh00000001, 1'b1, 1'b0, '0},
            // strictly descending set
            '{32'sh00000064, 1'b0, 1'b0, '0},
            '{32'sh00000032, 1'b0, 1'b0, '0},
            '{32'shffffffce, 1'b0, 1'b0, '0},
            '{32'shffffff9c, 1'b1, 1'b0, '0},
            // alternating bit patterns
            '{32'shaaaaaaaa, 1'b0, 1'b0, '0},
            '{32'sh55555555, 1'b0, 1'b0, '0},
            '{32'shffff0000, 1'b0, 1'b0, '0},
            '{32'sh0000ffff, 1'b1, 1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send_element(dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed,
                         dir_rows[r].want);

        // full store: one element and the final element dropped
        send_random_set(ms_pkg::MAX_ITEMS + 2);

        rand_items = 0;
        while (rand_items < RANDOM_SMALL_ITEMS) begin
            if ((idle_phase == 0 && rand_items >= 40) ||
                (idle_phase == 1 && rand_items >= 80)) begin
                // hold off until every sorted item is out, then change the idle and stall mix
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (sorted_expect.size() != 0) @(posedge i_clk);
                idle_phase++;
                send_idle_pct  = (idle_phase == 1) ? 68 : 0;
                recv_stall_pct = (idle_phase == 1) ? 38 : 0;
            end
            size = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            send_random_set(size);
            rand_items += size;
        end
        s_axis_tvalid <= 1'b0;

        while (sorted_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[merge_sorter_unit.f]
rtl/core/ms_pkg.sv
rtl/core/ms_merge_ctl.sv
rtl/core/merge_sorter_unit.sv
rtl/core/ms_checker.sv
dv/tb_merge_sorter_unit.sv
